FILE: rtl/convex_polygon_sat_overlap_core_assert.svh
// Assertion macros for the convex polygon overlap core checker.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef CONVEX_POLYGON_SAT_OVERLAP_CORE_ASSERT_SVH
`define CONVEX_POLYGON_SAT_OVERLAP_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPSAT_CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPSAT_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cpsat_pkg.sv
// Shared types and constants for the convex polygon overlap core.
// No dependencies; used by every module of the core.
`default_nettype none
package cpsat_pkg;

    localparam int MAX_VERTS_DEF  = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam int IN_COORD_W     = 16;
    localparam int SAT_W          = 25;
    localparam int OUT_DATA_W     = 8;

    typedef logic [1:0] tag_t;
    localparam tag_t TAG_NONE = 2'd0;
    localparam tag_t TAG_PREV = 2'd1;
    localparam tag_t TAG_EDGE = 2'd2;
    localparam tag_t TAG_PROJ = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_EMPTY = 2'd1;
    localparam status_t STAT_OVF   = 2'd2;

    typedef struct packed {
        logic ld;
        logic rd_en;
        logic rd_b;
        tag_t tag;
        logic first;
        logic clr;
    } cmd_t;

    typedef struct packed {
        logic ovf;
        logic sep;
    } sts_t;

endpackage
`default_nettype wire

FILE: rtl/convex_polygon_sat_overlap_core.sv
// Load: one vertex per cycle, s_tready high whenever no test is running.
// Test: a setup step, then per polygon a fetch of its closing vertex and, per edge, a sweep
// over the vertices of both polygons through the one read port of each vertex RAM; early exit
// on a gap. The result then sits in an output register while loading continues. Synchronous
// active-low reset clears counts and control; vertex RAMs are not cleared.
`default_nettype none
module convex_polygon_sat_overlap_core #(
    parameter int MAX_VERTS  = cpsat_pkg::MAX_VERTS_DEF,
    parameter int COORD_BITS = cpsat_pkg::COORD_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // vertex_x [15:0], vertex_y [31:16]
    input  wire logic [0:0]  s_tuser,   // req_type [0]
    input  wire logic        s_tlast,   // last_vertex
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [cpsat_pkg::OUT_DATA_W-1:0] m_tdata  // overlap [0], status [2:1], zero [7:3]
);

    localparam int ADDR_W = $clog2(MAX_VERTS);
    localparam int CNT_W  = $clog2(MAX_VERTS + 1);

    cpsat_pkg::cmd_t    cmd;
    cpsat_pkg::sts_t    sts;
    cpsat_pkg::status_t status;
    logic               overlap;
    logic [ADDR_W-1:0]  rd_addr;
    logic [CNT_W-1:0]   cnt_a, cnt_b;

    cpsat_ctrl #(.MAX_VERTS(MAX_VERTS)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_b       (s_tuser[0]),
        .s_last    (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_overlap (overlap),
        .m_status  (status),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .sts       (sts),
        .cnt_a     (cnt_a),
        .cnt_b     (cnt_b)
    );

    cpsat_dp #(.MAX_VERTS(MAX_VERTS), .COORD_BITS(COORD_BITS)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .in_b    (s_tuser[0]),
        .in_x    (s_tdata[15:0]),
        .in_y    (s_tdata[31:16]),
        .sts     (sts),
        .cnt_a   (cnt_a),
        .cnt_b   (cnt_b)
    );

    assign m_tdata = {{(cpsat_pkg::OUT_DATA_W - 3){1'b0}}, status, overlap};

endmodule
`default_nettype wire

FILE: rtl/cpsat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on cpsat_pkg for its parameter defaults.
`default_nettype none
module cpsat_ram #(
    parameter int WIDTH = 2 * cpsat_pkg::COORD_BITS_DEF,
    parameter int DEPTH = cpsat_pkg::MAX_VERTS_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/cpsat_dp.sv
// Datapath: vertex stores, counts, edge normal, projection pipeline, intervals.
// Depends on cpsat_pkg and cpsat_ram.
`default_nettype none
module cpsat_dp #(
    parameter int MAX_VERTS  = cpsat_pkg::MAX_VERTS_DEF,
    parameter int COORD_BITS = cpsat_pkg::COORD_BITS_DEF,
    localparam int ADDR_W    = $clog2(MAX_VERTS),
    localparam int CNT_W     = $clog2(MAX_VERTS + 1)
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire cpsat_pkg::cmd_t                            cmd,
    input  wire logic [ADDR_W-1:0]                          rd_addr,
    input  wire logic                                       in_b,
    input  wire logic signed [cpsat_pkg::IN_COORD_W-1:0]    in_x,
    input  wire logic signed [cpsat_pkg::IN_COORD_W-1:0]    in_y,
    output cpsat_pkg::sts_t                                 sts,
    output logic [CNT_W-1:0]                                cnt_a,
    output logic [CNT_W-1:0]                                cnt_b
);

    localparam int CB = COORD_BITS;
    localparam int AW = CB + 1;
    localparam int PW = 2 * CB + 1;
    localparam int DW = PW + 1;
    localparam int WW = 2 * CB;
    localparam logic signed [cpsat_pkg::SAT_W-1:0] C_HI =
        cpsat_pkg::SAT_W'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [cpsat_pkg::SAT_W-1:0] C_LO =
        cpsat_pkg::SAT_W'(-(1 << (COORD_BITS - 1)));

    logic signed [cpsat_pkg::SAT_W-1:0] ext_x, ext_y, sat_x, sat_y;
    logic [WW-1:0] wr_word;

    always_comb begin
        ext_x = cpsat_pkg::SAT_W'(in_x);
        ext_y = cpsat_pkg::SAT_W'(in_y);
        priority if (ext_x > C_HI) begin
            sat_x = C_HI;
        end else if (ext_x < C_LO) begin
            sat_x = C_LO;
        end else begin
            sat_x = ext_x;
        end
        priority if (ext_y > C_HI) begin
            sat_y = C_HI;
        end else if (ext_y < C_LO) begin
            sat_y = C_LO;
        end else begin
            sat_y = ext_y;
        end
    end

    assign wr_word = {sat_y[CB-1:0], sat_x[CB-1:0]};

    // vertex counts and overflow flag
    logic [CNT_W-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic             ovf_reg, ovf_next;
    logic             full_a, full_b, we_a, we_b;

    assign full_a = (cnt_a_reg == CNT_W'(MAX_VERTS));
    assign full_b = (cnt_b_reg == CNT_W'(MAX_VERTS));
    assign we_a   = cmd.ld && !in_b && !full_a;
    assign we_b   = cmd.ld && in_b && !full_b;

    always_comb begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        ovf_next   = ovf_reg;
        priority if (cmd.clr) begin
            cnt_a_next = '0;
            cnt_b_next = '0;
            ovf_next   = 1'b0;
        end else if (cmd.ld) begin
            if (in_b) begin
                if (full_b) begin
                    ovf_next = 1'b1;
                end else begin
                    cnt_b_next = cnt_b_reg + CNT_W'(1);
                end
            end else begin
                if (full_a) begin
                    ovf_next = 1'b1;
                end else begin
                    cnt_a_next = cnt_a_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign cnt_a = cnt_a_reg;
    assign cnt_b = cnt_b_reg;

    logic [WW-1:0] rdata_a, rdata_b;

    cpsat_ram #(.WIDTH(WW), .DEPTH(MAX_VERTS)) u_ram_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (cnt_a_reg[ADDR_W-1:0]),
        .wdata (wr_word),
        .re    (cmd.rd_en && !cmd.rd_b),
        .raddr (rd_addr),
        .rdata (rdata_a)
    );

    cpsat_ram #(.WIDTH(WW), .DEPTH(MAX_VERTS)) u_ram_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (cnt_b_reg[ADDR_W-1:0]),
        .wdata (wr_word),
        .re    (cmd.rd_en && cmd.rd_b),
        .raddr (rd_addr),
        .rdata (rdata_b)
    );

    // tag pipeline, aligned with read data, products and dot product
    cpsat_pkg::tag_t tag_d1_reg, tag_d2_reg, tag_d3_reg;
    logic b_d1_reg, b_d2_reg, b_d3_reg;
    logic first_d1_reg, first_d2_reg, first_d3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_d1_reg <= cpsat_pkg::TAG_NONE;
            tag_d2_reg <= cpsat_pkg::TAG_NONE;
            tag_d3_reg <= cpsat_pkg::TAG_NONE;
        end else begin
            tag_d1_reg <= cmd.rd_en ? cmd.tag : cpsat_pkg::TAG_NONE;
            tag_d2_reg <= tag_d1_reg;
            tag_d3_reg <= tag_d2_reg;
        end
        b_d1_reg     <= cmd.rd_b;
        b_d2_reg     <= b_d1_reg;
        b_d3_reg     <= b_d2_reg;
        first_d1_reg <= cmd.first;
        first_d2_reg <= first_d1_reg;
        first_d3_reg <= first_d2_reg;
    end

    logic [WW-1:0]        word;
    logic signed [CB-1:0] cur_x, cur_y;

    assign word  = b_d1_reg ? rdata_b : rdata_a;
    assign cur_x = word[CB-1:0];
    assign cur_y = word[WW-1:CB];

    // edge normal: (-(yi - yj), xi - xj) with j the previous vertex
    logic signed [CB-1:0] prev_x_reg, prev_y_reg;
    logic signed [AW-1:0] ax_reg, ay_reg;
    logic signed [PW-1:0] px_reg, py_reg;
    logic signed [DW-1:0] dot_reg;

    always_ff @(posedge aclk) begin
        if (tag_d1_reg == cpsat_pkg::TAG_PREV || tag_d1_reg == cpsat_pkg::TAG_EDGE) begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
        if (tag_d1_reg == cpsat_pkg::TAG_EDGE) begin
            ax_reg <= AW'(prev_y_reg) - AW'(cur_y);
            ay_reg <= AW'(cur_x) - AW'(prev_x_reg);
        end
        px_reg  <= PW'(ax_reg) * PW'(cur_x);
        py_reg  <= PW'(ay_reg) * PW'(cur_y);
        dot_reg <= DW'(px_reg) + DW'(py_reg);
    end

    // projection intervals
    logic signed [DW-1:0] min_a_reg, max_a_reg, min_b_reg, max_b_reg;

    always_ff @(posedge aclk) begin
        if (tag_d3_reg == cpsat_pkg::TAG_PROJ) begin
            if (b_d3_reg) begin
                if (first_d3_reg || dot_reg < min_b_reg) begin
                    min_b_reg <= dot_reg;
                end
                if (first_d3_reg || dot_reg > max_b_reg) begin
                    max_b_reg <= dot_reg;
                end
            end else begin
                if (first_d3_reg || dot_reg < min_a_reg) begin
                    min_a_reg <= dot_reg;
                end
                if (first_d3_reg || dot_reg > max_a_reg) begin
                    max_a_reg <= dot_reg;
                end
            end
        end
    end

    assign sts.sep = (min_a_reg > max_b_reg) || (min_b_reg > max_a_reg);
    assign sts.ovf = ovf_reg;

endmodule
`default_nettype wire

FILE: rtl/cpsat_ctrl.sv
// Controller: load handshake, edge and sweep sequencing, result register.
// Depends on cpsat_pkg; drives cpsat_dp through cmd_t and reads sts_t.
`default_nettype none
module cpsat_ctrl #(
    parameter int MAX_VERTS = cpsat_pkg::MAX_VERTS_DEF,
    localparam int ADDR_W   = $clog2(MAX_VERTS),
    localparam int CNT_W    = $clog2(MAX_VERTS + 1)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic                s_b,
    input  wire logic                s_last,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic                     m_overlap,
    output cpsat_pkg::status_t       m_status,
    output cpsat_pkg::cmd_t          cmd,
    output logic [ADDR_W-1:0]        rd_addr,
    input  wire cpsat_pkg::sts_t     sts,
    input  wire logic [CNT_W-1:0]    cnt_a,
    input  wire logic [CNT_W-1:0]    cnt_b
);

    localparam logic [3:0] ST_LOAD    = 4'd0;
    localparam logic [3:0] ST_CHECK   = 4'd1;
    localparam logic [3:0] ST_PRIME   = 4'd2;
    localparam logic [3:0] ST_PRIME_W = 4'd3;
    localparam logic [3:0] ST_EDGE    = 4'd4;
    localparam logic [3:0] ST_EDGE_W  = 4'd5;
    localparam logic [3:0] ST_SWEEP   = 4'd6;
    localparam logic [3:0] ST_DRAIN   = 4'd7;
    localparam logic [3:0] ST_DECIDE  = 4'd8;
    localparam logic [3:0] ST_EMIT    = 4'd9;

    localparam logic [1:0] DRAIN_LAST = 2'd2;

    logic [3:0]         state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next, k_reg, k_next;
    logic               edge_b_reg, edge_b_next, sweep_b_reg, sweep_b_next;
    logic [1:0]         drn_reg, drn_next;
    logic               res_ov_reg, res_ov_next;
    cpsat_pkg::status_t res_st_reg, res_st_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               out_ov_reg, out_ov_next;
    cpsat_pkg::status_t out_st_reg, out_st_next;

    logic [CNT_W-1:0] n_edge_m1, n_sweep_m1;
    logic             out_free;

    assign n_edge_m1  = (edge_b_reg ? cnt_b : cnt_a) - CNT_W'(1);
    assign n_sweep_m1 = (sweep_b_reg ? cnt_b : cnt_a) - CNT_W'(1);
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        k_next        = k_reg;
        edge_b_next   = edge_b_reg;
        sweep_b_next  = sweep_b_reg;
        drn_next      = drn_reg;
        res_ov_next   = res_ov_reg;
        res_st_next   = res_st_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_ov_next   = out_ov_reg;
        out_st_next   = out_st_reg;
        cmd           = '0;
        cmd.tag       = cpsat_pkg::TAG_NONE;
        rd_addr       = '0;
        unique case (state_reg)
            ST_LOAD: begin
                cmd.ld = s_tvalid;
                if (s_tvalid && s_b && s_last) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                res_ov_next = 1'b0;
                priority if (sts.ovf) begin
                    res_st_next = cpsat_pkg::STAT_OVF;
                    state_next  = ST_EMIT;
                end else if (cnt_a == '0 || cnt_b == '0) begin
                    res_st_next = cpsat_pkg::STAT_EMPTY;
                    state_next  = ST_EMIT;
                end else begin
                    res_st_next = cpsat_pkg::STAT_OK;
                    edge_b_next = 1'b0;
                    idx_next    = '0;
                    state_next  = ST_PRIME;
                end
            end
            ST_PRIME: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_b   = edge_b_reg;
                cmd.tag    = cpsat_pkg::TAG_PREV;
                rd_addr    = n_edge_m1[ADDR_W-1:0];
                state_next = ST_PRIME_W;
            end
            ST_PRIME_W: begin
                state_next = ST_EDGE;
            end
            ST_EDGE: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_b   = edge_b_reg;
                cmd.tag    = cpsat_pkg::TAG_EDGE;
                rd_addr    = idx_reg[ADDR_W-1:0];
                state_next = ST_EDGE_W;
            end
            ST_EDGE_W: begin
                k_next       = '0;
                sweep_b_next = 1'b0;
                state_next   = ST_SWEEP;
            end
            ST_SWEEP: begin
                cmd.rd_en = 1'b1;
                cmd.rd_b  = sweep_b_reg;
                cmd.tag   = cpsat_pkg::TAG_PROJ;
                cmd.first = (k_reg == '0);
                rd_addr   = k_reg[ADDR_W-1:0];
                if (k_reg == n_sweep_m1) begin
                    k_next = '0;
                    if (!sweep_b_reg) begin
                        sweep_b_next = 1'b1;
                    end else begin
                        drn_next   = '0;
                        state_next = ST_DRAIN;
                    end
                end else begin
                    k_next = k_reg + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (drn_reg == DRAIN_LAST) begin
                    state_next = ST_DECIDE;
                end else begin
                    drn_next = drn_reg + 2'd1;
                end
            end
            ST_DECIDE: begin
                priority if (sts.sep) begin
                    res_ov_next = 1'b0;
                    state_next  = ST_EMIT;
                end else if (idx_reg == n_edge_m1) begin
                    idx_next = '0;
                    if (!edge_b_reg) begin
                        edge_b_next = 1'b1;
                        state_next  = ST_PRIME;
                    end else begin
                        res_ov_next = 1'b1;
                        state_next  = ST_EMIT;
                    end
                end else begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_EDGE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    out_ov_next   = res_ov_reg;
                    out_st_next   = res_st_reg;
                    cmd.clr       = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        idx_reg     <= idx_next;
        k_reg       <= k_next;
        edge_b_reg  <= edge_b_next;
        sweep_b_reg <= sweep_b_next;
        drn_reg     <= drn_next;
        res_ov_reg  <= res_ov_next;
        res_st_reg  <= res_st_next;
        out_ov_reg  <= out_ov_next;
        out_st_reg  <= out_st_next;
    end

    assign s_tready  = (state_reg == ST_LOAD);
    assign m_tvalid  = m_tvalid_reg;
    assign m_overlap = out_ov_reg;
    assign m_status  = out_st_reg;

endmodule
`default_nettype wire

FILE: rtl/cpsat_checker.sv
// Port-level checker for the convex polygon overlap core, bound to the top level.
// Depends on cpsat_pkg and convex_polygon_sat_overlap_core_assert.svh.
`default_nettype none
`include "convex_polygon_sat_overlap_core_assert.svh"
module cpsat_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,
    input wire logic [0:0]  s_tuser,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [cpsat_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic s_xfer_b_last;

    assign s_xfer_b_last = s_tvalid && s_tready && s_tlast && s_tuser[0] && (s_tdata == s_tdata);

    `CPSAT_CHK_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `CPSAT_CHK_SAME(a_status_code, m_tvalid, m_tdata[2:1] != 2'd3, "undefined status code")
    `CPSAT_CHK_SAME(a_fail_no_overlap, m_tvalid && m_tdata[2:1] != cpsat_pkg::STAT_OK, !m_tdata[0], "overlap set with failing status")
    `CPSAT_CHK_NEXT(a_test_blocks_load, s_xfer_b_last, !s_tready, "vertex taken while test starts")

endmodule

bind convex_polygon_sat_overlap_core cpsat_checker u_cpsat_checker (.*);
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking bench for convex_polygon_sat_overlap_core: streams polygon vertex pairs and
// checks each result's overlap, status and padding against an in-bench separating axis predictor.
// Depends on cpsat_pkg and the core RTL only.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    localparam int  MAXV       = cpsat_pkg::MAX_VERTS_DEF;
    localparam int  CBITS      = cpsat_pkg::COORD_BITS_DEF;
    localparam int  RAND_ITEMS = 1250;
    localparam int  PAUSE_AT   = 600;
    localparam int  HOLD_AFTER = 12;
    localparam int  HOLD_CYC   = 6000;
    localparam int  DRAIN_CYC  = 1500;
    localparam int  LIMIT_CYC  = 4000000;
    localparam bit  POLY_A     = 1'b0;
    localparam bit  POLY_B     = 1'b1;

    typedef struct packed {
        logic               marker;
        logic               is_b;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
        logic               fixed;
        logic               fix_overlap;
        cpsat_pkg::status_t fix_status;
    } vtx_item_t;

    typedef struct packed {
        logic               overlap;
        cpsat_pkg::status_t status;
    } sat_verdict_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_SPARSE} rx_mode_e;
    typedef enum int {SEQ_PAIR, SEQ_OVF_A, SEQ_OVF_B, SEQ_NO_A, SEQ_NOISE} seq_kind_e;

    localparam int TPL [16] = '{1000, 924, 707, 383, 0, -383, -707, -924,
                                -1000, -924, -707, -383, 0, 383, 707, 924};

    localparam int DIR_N = 25;
    localparam vtx_item_t DIR_TAB [DIR_N] = '{
        '{1'b0, POLY_B, 16'sd5, 16'sd5, 1'b1, 1'b1, 1'b0, cpsat_pkg::STAT_EMPTY},
        '{1'b0, POLY_A, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_A, 16'sd10, 16'sd0, 1'b0, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_A, 16'sd0, 16'sd10, 1'b0, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_B, 16'sd1, 16'sd1, 1'b0, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_B, 16'sd20, 16'sd1, 1'b0, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_B, 16'sd1, 16'sd20, 1'b1, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_A, 16'sd100, -16'sd100, 1'b1, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_B, 16'sd100, -16'sd100, 1'b1, 1'b1, 1'b1, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_A, 16'sh8000, 16'sh8000, 1'b0, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_A, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_A, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_A, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_B, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_A, 16'sh8000, 16'sh8000, 1'b0, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_A, 16'sh8000, 16'sh8001, 1'b0, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_B, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_B, 16'sh7FFF, 16'sh7FFE, 1'b1, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_A, 16'sd3, 16'sd3, 1'b0, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_A, 16'sd3, 16'sd3, 1'b0, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_A, 16'sd8, 16'sd3, 1'b0, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_A, 16'sd3, 16'sd9, 1'b0, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_B, 16'sd4, 16'sd4, 1'b0, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_B, 16'sd4, 16'sd4, 1'b1, 1'b0, 1'b0, cpsat_pkg::STAT_OK},
        '{1'b0, POLY_B, -16'sd1, -16'sd1, 1'b1, 1'b1, 1'b0, cpsat_pkg::STAT_EMPTY}
    };

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [31:0]                      s_tdata  = '0;
    logic [0:0]                       s_tuser  = '0;
    logic                             s_tlast  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [cpsat_pkg::OUT_DATA_W-1:0] m_tdata;

    convex_polygon_sat_overlap_core #(
        .MAX_VERTS  (MAXV),
        .COORD_BITS (CBITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    vtx_item_t    stim_q [$];
    sat_verdict_t verdict_q [$];
    vtx_item_t    cur_item;
    int           stim_items;
    int           err_cnt;
    int           got_cnt;
    int           cyc;

    // predictor state
    longint       a_x [MAXV];
    longint       a_y [MAXV];
    longint       b_x [MAXV];
    longint       b_y [MAXV];
    int           cnt_a;
    int           cnt_b;
    bit           ovf_seen;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch @%0d: %s got %h want %h", cyc, what, got, want);
        err_cnt++;
    endtask

    function automatic longint sat_coord(logic signed [15:0] raw);
        longint v;
        longint hi;
        longint lo;
        v  = longint'(raw);
        hi = (longint'(1) << (CBITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v;
    endfunction

    function automatic void shape_span(bit of_b, longint ax, longint ay,
                                       output longint lo, output longint hi);
        longint d;
        int     n;
        n  = of_b ? cnt_b : cnt_a;
        lo = 0;
        hi = 0;
        for (int i = 0; i < n; i++) begin
            d = of_b ? ax * b_x[i] + ay * b_y[i] : ax * a_x[i] + ay * a_y[i];
            if (i == 0 || d < lo) lo = d;
            if (i == 0 || d > hi) hi = d;
        end
    endfunction

    function automatic bit axis_gap_found(bit edges_of_b);
        int     n;
        int     j;
        longint ax;
        longint ay;
        longint mina;
        longint maxa;
        longint minb;
        longint maxb;
        n = edges_of_b ? cnt_b : cnt_a;
        for (int i = 0; i < n; i++) begin
            j = (i == 0) ? n - 1 : i - 1;
            if (edges_of_b) begin
                ax = -(b_y[i] - b_y[j]);
                ay = b_x[i] - b_x[j];
            end else begin
                ax = -(a_y[i] - a_y[j]);
                ay = a_x[i] - a_x[j];
            end
            shape_span(1'b0, ax, ay, mina, maxa);
            shape_span(1'b1, ax, ay, minb, maxb);
            if (mina > maxb || minb > maxa) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic take_vertex(vtx_item_t it);
        sat_verdict_t res;
        if (it.is_b) begin
            if (cnt_b < MAXV) begin
                b_x[cnt_b] = sat_coord(it.x);
                b_y[cnt_b] = sat_coord(it.y);
                cnt_b++;
            end else begin
                ovf_seen = 1'b1;
            end
        end else begin
            if (cnt_a < MAXV) begin
                a_x[cnt_a] = sat_coord(it.x);
                a_y[cnt_a] = sat_coord(it.y);
                cnt_a++;
            end else begin
                ovf_seen = 1'b1;
            end
        end
        if (!(it.is_b && it.last)) return;
        res.overlap = 1'b0;
        res.status  = cpsat_pkg::STAT_OK;
        if (ovf_seen) begin
            res.status = cpsat_pkg::STAT_OVF;
        end else if (cnt_a == 0 || cnt_b == 0) begin
            res.status = cpsat_pkg::STAT_EMPTY;
        end else begin
            res.overlap = !(axis_gap_found(1'b0) || axis_gap_found(1'b1));
        end
        if (it.fixed) begin
            res.overlap = it.fix_overlap;
            res.status  = it.fix_status;
        end
        verdict_q.insert(verdict_q.size(), res);
        cnt_a    = 0;
        cnt_b    = 0;
        ovf_seen = 1'b0;
    endtask

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    task automatic push_vtx(bit is_b, logic signed [15:0] x, logic signed [15:0] y, bit last);
        vtx_item_t it;
        it = '{1'b0, is_b, x, y, last, 1'b0, 1'b0, cpsat_pkg::STAT_OK};
        stim_q.insert(stim_q.size(), it);
        stim_items++;
    endtask

    // ordered subset of a 16-gon template stays convex
    task automatic add_shape(bit is_b, int n, int cx, int cy, int scale, bit close);
        int pick [$];
        int need;
        int rot;
        int idx;
        bit rev;
        need = n;
        for (int k = 0; k < 16; k++) begin
            if ($urandom_range(1, 16 - k) <= need) begin
                pick.insert(pick.size(), k);
                need--;
            end
        end
        rot = $urandom_range(0, n - 1);
        rev = 1'($urandom_range(0, 1));
        for (int k = 0; k < n; k++) begin
            idx = pick[(rot + (rev ? n - 1 - k : k)) % n];
            push_vtx(is_b, clamp16(cx + scale * TPL[idx]),
                     clamp16(cy + scale * TPL[(idx + 12) % 16]), close && k == n - 1);
        end
    endtask

    function automatic int pick_size();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 5);
    endfunction

    task automatic add_pair(bit with_a, int n_a, int n_b);
        int cx;
        int cy;
        int sa;
        int sb;
        int reach;
        sa    = $urandom_range(0, 16);
        sb    = $urandom_range(0, 16);
        cx    = $urandom_range(0, 28000) - 14000;
        cy    = $urandom_range(0, 28000) - 14000;
        reach = (sa + sb) * 1200 + 1;
        if (with_a) add_shape(POLY_A, n_a, cx, cy, sa, 1'($urandom_range(0, 1)));
        cx = cx + $urandom_range(0, 2 * reach) - reach;
        cy = cy + $urandom_range(0, 2 * reach) - reach;
        add_shape(POLY_B, n_b, cx, cy, sb, n_b > 0);
    endtask

    task automatic build_stimulus();
        seq_kind_e kind;
        int        roll;
        int        extra;
        bit        paused;
        vtx_item_t hold_item;
        paused = 1'b0;
        for (int r = 0; r < DIR_N; r++) begin
            stim_q.insert(stim_q.size(), DIR_TAB[r]);
        end
        stim_items = 0;
        while (stim_items < RAND_ITEMS) begin
            roll = $urandom_range(0, 99);
            kind = roll < 66 ? SEQ_PAIR : roll < 72 ? SEQ_OVF_A : roll < 78 ? SEQ_OVF_B :
                   roll < 84 ? SEQ_NO_A : SEQ_NOISE;
            case (kind)
                SEQ_PAIR: begin
                    add_pair(1'b1, pick_size(), pick_size());
                end
                SEQ_OVF_A: begin
                    add_shape(POLY_A, MAXV, 0, 0, $urandom_range(1, 16), 1'b0);
                    extra = $urandom_range(1, 3);
                    repeat (extra) begin
                        push_vtx(POLY_A, 16'($urandom), 16'($urandom),
                                 1'($urandom_range(0, 1)));
                    end
                    add_pair(1'b0, 0, pick_size());
                end
                SEQ_OVF_B: begin
                    if ($urandom_range(0, 1)) add_shape(POLY_A, pick_size(), 0, 0, 5, 1'b0);
                    add_shape(POLY_B, MAXV, 0, 0, $urandom_range(1, 16), 1'b0);
                    extra = $urandom_range(1, 3);
                    repeat (extra - 1) push_vtx(POLY_B, 16'($urandom), 16'($urandom), 1'b0);
                    push_vtx(POLY_B, 16'($urandom), 16'($urandom), 1'b1);
                end
                SEQ_NO_A: begin
                    add_pair(1'b0, 0, pick_size());
                end
                SEQ_NOISE: begin
                    extra = $urandom_range(1, 6);
                    repeat (extra) begin
                        push_vtx(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                                 $urandom_range(0, 3) == 0);
                    end
                end
                default: ;
            endcase
            if (!paused && stim_items >= PAUSE_AT) begin
                paused    = 1'b1;
                hold_item = '0;
                hold_item.marker = 1'b1;
                stim_q.insert(stim_q.size(), hold_item);
            end
        end
    endtask

    // sender: bursts of transfers separated by random gaps
    int burst_left;
    int gap_left;

    always @(posedge aclk) begin : drive_blk
        vtx_item_t nxt;
        bit        busy;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
            cnt_a      = 0;
            cnt_b      = 0;
            ovf_seen   = 1'b0;
        end else begin
            busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                take_vertex(cur_item);
                busy = 1'b0;
            end
            if (busy) begin
                s_tvalid <= 1'b1;
            end else if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (stim_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (stim_q[0].marker) begin
                if (verdict_q.size() == 0) void'(stim_q.pop_front());
                s_tvalid <= 1'b0;
            end else begin
                nxt = stim_q.pop_front();
                cur_item <= nxt;
                s_tdata  <= {nxt.y, nxt.x};
                s_tuser  <= nxt.is_b;
                s_tlast  <= nxt.last;
                s_tvalid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
        end
    end

    // long receiver hold-off once, counted here
    bit hold_on;
    int hold_left;
    bit hold_done;

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_on   <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            if (hold_left == 0) hold_on <= 1'b0;
        end else if (!hold_done && got_cnt >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYC;
            hold_on   <= 1'b1;
        end
    end

    rx_mode_e rx_mode;
    int       mode_left;

    always @(posedge aclk) begin : recv_blk
        sat_verdict_t want;
        bit           rdy;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            got_cnt   <= 0;
            mode_left = 0;
            rx_mode   = RX_OPEN;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("result with none pending", 32'(m_tdata), '0);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want.overlap)
                        report_mismatch("overlap", 32'(m_tdata[0]), 32'(want.overlap));
                    if (m_tdata[2:1] !== want.status)
                        report_mismatch("status", 32'(m_tdata[2:1]), 32'(want.status));
                    if (m_tdata[cpsat_pkg::OUT_DATA_W-1:3] !== '0)
                        report_mismatch("padding", 32'(m_tdata[cpsat_pkg::OUT_DATA_W-1:3]),
                                        '0);
                end
                got_cnt <= got_cnt + 1;
            end
            if (mode_left == 0) begin
                rx_mode   = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 300);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_OPEN:   rdy = 1'b1;
                RX_COIN:   rdy = 1'($urandom_range(0, 1));
                RX_COMB:   rdy = (cyc % 7) < 4;
                RX_SPARSE: rdy = $urandom_range(0, 3) == 0;
                default:   rdy = 1'b1;
            endcase
            m_tready <= !hold_on && rdy;
        end
    end

    always @(posedge aclk) begin
        cyc++;
        if (cyc >= LIMIT_CYC) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        err_cnt = 0;
        cyc     = 0;
        build_stimulus();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        while (stim_q.size() != 0 || s_tvalid || verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/cpsat_pkg.sv
rtl/cpsat_ram.sv
rtl/cpsat_dp.sv
rtl/cpsat_ctrl.sv
rtl/convex_polygon_sat_overlap_core.sv
rtl/cpsat_checker.sv
dv/tb_top.sv
